FILE: design/smalu_pkg.sv
package smalu_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int WORD_W      = 32;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int OUT_CNT_W   = 11;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DIV_CNT_W   = $clog2(WORD_W);

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_MOD  = 3'd4;
	localparam logic [OP_W-1:0] OP_SWAP = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERODIV = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // latch instruction, issue read of second word
		logic decode;    // latch status of the prechecks
		logic mul;       // register product
		logic div_init;  // load divider magnitudes
		logic div_step;  // one restoring step
		logic commit;    // update stack, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err;
		logic is_mul;
		logic is_div;
		logic div_last;
	} sts_t;

endpackage

FILE: design/smalu_ctrl.sv
module smalu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  smalu_pkg::sts_t   sts,
	output smalu_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !(out_valid_q && out_stall);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.err) begin
					state_d = S_FIN;
				end else if (sts.is_mul) begin
					state_d = S_MUL;
				end else if (sts.is_div) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/smalu_dpath.sv
module smalu_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  smalu_pkg::cmd_t                        cmd,
	output smalu_pkg::sts_t                        sts,
	input  logic        [smalu_pkg::OP_W-1:0]      opcode,
	input  logic signed [smalu_pkg::WORD_W-1:0]    push_value,
	output logic        [smalu_pkg::STATUS_W-1:0]  status,
	output logic signed [smalu_pkg::WORD_W-1:0]    top_value,
	output logic        [smalu_pkg::OUT_CNT_W-1:0] stack_count
);

	localparam int W = smalu_pkg::WORD_W;

	// words below the top; the top word lives in top_q
	logic [W-1:0] mem [smalu_pkg::STACK_DEPTH];

	logic [smalu_pkg::CNT_W-1:0]    count_q;
	logic [smalu_pkg::CNT_W-1:0]    count_d;
	logic [W-1:0]                   top_q;
	logic [W-1:0]                   top_d;
	logic [W-1:0]                   sec_q;
	logic [smalu_pkg::OP_W-1:0]     op_q;
	logic [W-1:0]                   pv_q;
	logic [smalu_pkg::STATUS_W-1:0] st_q;
	logic [smalu_pkg::STATUS_W-1:0] st_chk;

	logic [smalu_pkg::CNT_W-1:0]  cnt_m1;
	logic [smalu_pkg::CNT_W-1:0]  cnt_m2;
	logic                         wr_en;
	logic [smalu_pkg::ADDR_W-1:0] wr_addr;

	logic [W-1:0] prod_full;
	logic [W-1:0] prod_q;

	logic [W-1:0]                    rem_q;
	logic [W-1:0]                    quo_q;
	logic [W-1:0]                    mb_q;
	logic                            neg_q_q;
	logic                            neg_r_q;
	logic [smalu_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [W:0]                      trial;
	logic [W:0]                      shifted;
	logic [W-1:0]                    quo_fin;
	logic [W-1:0]                    rem_fin;

	logic [smalu_pkg::STATUS_W-1:0]  status_q;
	logic [W-1:0]                    top_out_q;
	logic [smalu_pkg::OUT_CNT_W-1:0] cnt_out_q;

	assign cnt_m1 = count_q - smalu_pkg::CNT_W'(1);
	assign cnt_m2 = count_q - smalu_pkg::CNT_W'(2);

	// prechecks on the latched instruction
	always_comb begin
		st_chk = smalu_pkg::ST_OK;
		case (op_q)
			smalu_pkg::OP_PUSH: begin
				if (count_q == smalu_pkg::CNT_W'(smalu_pkg::STACK_DEPTH)) begin
					st_chk = smalu_pkg::ST_OVER;
				end
			end
			smalu_pkg::OP_SUB, smalu_pkg::OP_MUL, smalu_pkg::OP_SWAP: begin
				if (count_q < smalu_pkg::CNT_W'(2)) begin
					st_chk = smalu_pkg::ST_UNDER;
				end
			end
			smalu_pkg::OP_DIV, smalu_pkg::OP_MOD: begin
				if (count_q < smalu_pkg::CNT_W'(2)) begin
					st_chk = smalu_pkg::ST_UNDER;
				end else if (top_q == '0) begin
					st_chk = smalu_pkg::ST_ZERODIV;
				end
			end
			default: begin
				st_chk = smalu_pkg::ST_OK;
			end
		endcase
	end

	assign sts.err      = (st_chk != smalu_pkg::ST_OK);
	assign sts.is_mul   = (op_q == smalu_pkg::OP_MUL);
	assign sts.is_div   = (op_q == smalu_pkg::OP_DIV) || (op_q == smalu_pkg::OP_MOD);
	assign sts.div_last = (div_cnt_q == smalu_pkg::DIV_CNT_W'(W - 1));

	// restoring divider on magnitudes
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, mb_q};
	assign quo_fin = neg_q_q ? (W'(0) - quo_q) : quo_q;
	assign rem_fin = neg_r_q ? (W'(0) - rem_q) : rem_q;

	// low word of the product only
	assign prod_full = sec_q * top_q;

	// result of the instruction, applied on commit
	always_comb begin
		top_d   = top_q;
		count_d = count_q;
		wr_en   = 1'b0;
		wr_addr = cnt_m1[smalu_pkg::ADDR_W-1:0];
		if (st_q == smalu_pkg::ST_OK) begin
			case (op_q)
				smalu_pkg::OP_PUSH: begin
					top_d   = pv_q;
					count_d = count_q + smalu_pkg::CNT_W'(1);
					wr_en   = (count_q != '0);
				end
				smalu_pkg::OP_SUB: begin
					top_d   = sec_q - top_q;
					count_d = cnt_m1;
				end
				smalu_pkg::OP_MUL: begin
					top_d   = prod_q;
					count_d = cnt_m1;
				end
				smalu_pkg::OP_DIV: begin
					top_d   = quo_fin;
					count_d = cnt_m1;
				end
				smalu_pkg::OP_MOD: begin
					top_d   = rem_fin;
					count_d = cnt_m1;
				end
				smalu_pkg::OP_SWAP: begin
					top_d   = sec_q;
					wr_en   = 1'b1;
					wr_addr = cnt_m2[smalu_pkg::ADDR_W-1:0];
				end
				default: begin
					top_d = top_q;
				end
			endcase
		end
	end

	// stack memory: read at accept, write at commit
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sec_q <= mem[cnt_m2[smalu_pkg::ADDR_W-1:0]];
		end
		if (cmd.commit && wr_en) begin
			mem[wr_addr] <= top_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= opcode;
			pv_q <= push_value;
		end
		if (cmd.decode) begin
			st_q <= st_chk;
		end
		if (cmd.mul) begin
			prod_q <= prod_full;
		end
		if (cmd.div_init) begin
			rem_q   <= '0;
			quo_q   <= sec_q[W-1] ? (W'(0) - sec_q) : sec_q;
			mb_q    <= top_q[W-1] ? (W'(0) - top_q) : top_q;
			neg_q_q <= sec_q[W-1] ^ top_q[W-1];
			neg_r_q <= sec_q[W-1];
		end else if (cmd.div_step) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			top_q     <= top_d;
			status_q  <= st_q;
			top_out_q <= (count_d == '0) ? '0 : top_d;
			cnt_out_q <= smalu_pkg::OUT_CNT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.commit) begin
				count_q <= count_d;
			end
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + smalu_pkg::DIV_CNT_W'(1);
			end
		end
	end

	assign status      = status_q;
	assign top_value   = top_out_q;
	assign stack_count = cnt_out_q;

endmodule

FILE: design/stack_machine_alu_unit.sv
// channel  signals                                    direction
// in       in_valid, in_stall, opcode, push_value     item in
// out      out_valid, out_stall, status, top_value,   result out
//          stack_count
//
// Push, sub, swap, unused opcodes and errors pass from transfer through decode to
// commit; mul adds a product step, div and mod run 32 steps of the radix-2 divider.
// The top word sits in a register; the words below it are in a single-port
// stack memory read once per item, so no clearing pass is needed after reset.
// Reset empties the stack. A stalled result holds the next item at its final
// cycle, while the input is taken again as soon as the previous item commits.
module stack_machine_alu_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic        [smalu_pkg::OP_W-1:0]      opcode,
	input  logic signed [smalu_pkg::WORD_W-1:0]    push_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic        [smalu_pkg::STATUS_W-1:0]  status,
	output logic signed [smalu_pkg::WORD_W-1:0]    top_value,
	output logic        [smalu_pkg::OUT_CNT_W-1:0] stack_count
);

	smalu_pkg::cmd_t cmd;
	smalu_pkg::sts_t sts;

	smalu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	smalu_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.push_value  (push_value),
		.status      (status),
		.top_value   (top_value),
		.stack_count (stack_count)
	);

endmodule

FILE: dv/stack_machine_alu_checker.sv
module stack_machine_alu_checker
	import smalu_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic        [OP_W-1:0]      opcode,
	input  logic signed [WORD_W-1:0]    push_value,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic        [STATUS_W-1:0]  status,
	input  logic signed [WORD_W-1:0]    top_value,
	input  logic        [OUT_CNT_W-1:0] stack_count,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [WORD_W-1:0]    top;
		logic [OUT_CNT_W-1:0] count;
	} stack_result_t;

	stack_result_t predicted_results[$];
	stack_result_t want;
	logic [WORD_W-1:0] words[STACK_DEPTH];
	int unsigned depth;
	int errors = 0;

	function automatic stack_result_t apply_instruction(logic [OP_W-1:0] op,
			logic [WORD_W-1:0] val);
		stack_result_t r;
		logic [WORD_W-1:0] tos, nos, mag_n, mag_d, quo, rem;
		r.status = ST_OK;
		case (op)
			OP_PUSH: begin
				if (depth >= STACK_DEPTH) begin
					r.status = ST_OVER;
				end else begin
					words[depth] = val;
					depth++;
				end
			end
			OP_SUB, OP_DIV, OP_MUL, OP_MOD, OP_SWAP: begin
				if (depth < 2) begin
					r.status = ST_UNDER;
				end else begin
					tos = words[depth-1];
					nos = words[depth-2];
					case (op)
						OP_SUB: begin
							words[depth-2] = nos - tos;
							depth--;
						end
						OP_MUL: begin
							words[depth-2] = nos * tos;
							depth--;
						end
						OP_SWAP: begin
							words[depth-2] = tos;
							words[depth-1] = nos;
						end
						default: begin
							if (tos == '0) begin
								r.status = ST_ZERODIV;
							end else begin
								// truncate toward zero on magnitudes, remainder follows dividend
								mag_n = nos[WORD_W-1] ? -nos : nos;
								mag_d = tos[WORD_W-1] ? -tos : tos;
								quo = mag_n / mag_d;
								rem = mag_n % mag_d;
								if (nos[WORD_W-1] ^ tos[WORD_W-1])
									quo = -quo;
								if (nos[WORD_W-1])
									rem = -rem;
								words[depth-2] = (op == OP_DIV) ? quo : rem;
								depth--;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
		r.top = (depth > 0) ? words[depth-1] : '0;
		r.count = OUT_CNT_W'(depth);
		return r;
	endfunction

	task automatic report(string field, longint exp_val, longint act_val);
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, act_val);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth = 0;
			predicted_results.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (in_valid && !in_stall)
				predicted_results.push_back(apply_instruction(opcode, push_value));
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result transfer, status %0d top %0d count %0d",
						$time, status, top_value, stack_count);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					if (status !== want.status)
						report("status", want.status, status);
					if (top_value !== want.top)
						report("top_value", $signed(want.top), top_value);
					if (stack_count !== want.count)
						report("stack_count", want.count, stack_count);
				end
			end
			pending <= predicted_results.size();
			fail_count <= errors;
		end
	end

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import smalu_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic        [OP_W-1:0]      opcode;
	logic signed [WORD_W-1:0]    push_value;
	logic                        out_valid;
	logic                        out_stall;
	logic        [STATUS_W-1:0]  status;
	logic signed [WORD_W-1:0]    top_value;
	logic        [OUT_CNT_W-1:0] stack_count;

	int fail_count;
	int pending;
	int gap_pct;
	int stall_pct;
	bit hold_req;
	int level;
	int cycle_count = 0;

	stack_machine_alu_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.top_value   (top_value),
		.stack_count (stack_count)
	);

	stack_machine_alu_checker stack_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.top_value   (top_value),
		.stack_count (stack_count),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off when requested
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return 32'h8000_0000;
			4: return 32'h7fff_ffff;
			5, 6: return 32'($urandom_range(40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	// one transfer on the instruction channel; level roughly follows the stack depth
	task automatic issue(logic [OP_W-1:0] op, logic [WORD_W-1:0] val);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		push_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (op)
			OP_PUSH: if (level < STACK_DEPTH) level++;
			OP_SUB, OP_DIV, OP_MUL, OP_MOD: if (level >= 2) level--;
			default: ;
		endcase
	endtask

	task automatic random_item(int push_w);
		int sel;
		logic [OP_W-1:0] op;
		sel = $urandom_range(99);
		if (sel < push_w)
			op = OP_PUSH;
		else if (sel >= 98)
			op = OP_W'($urandom_range(OP_SPARE7, OP_SPARE6));
		else
			op = OP_W'($urandom_range(OP_SWAP, OP_SUB));
		issue(op, pick_word());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_PUSH;
		push_value = '0;
		gap_pct = 36;
		stall_pct = 66;
		hold_req = 1'b0;
		level = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_SUB, $urandom);           // empty stack
		issue(OP_PUSH, 32'h7fff_ffff);
		issue(OP_SWAP, $urandom);          // single entry
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_SUB, $urandom);           // wraps to -1
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_SWAP, $urandom);
		issue(OP_DIV, $urandom);           // min / -1 wraps
		issue(OP_PUSH, '1);
		issue(OP_MOD, $urandom);           // min mod -1
		issue(OP_PUSH, '0);
		issue(OP_DIV, $urandom);           // zero divisor
		issue(OP_MOD, $urandom);
		issue(OP_MUL, $urandom);
		issue(OP_PUSH, -32'sd7);
		issue(OP_PUSH, 32'd2);
		issue(OP_DIV, $urandom);           // truncates toward zero
		issue(OP_PUSH, 32'd2);
		issue(OP_MOD, $urandom);           // remainder takes dividend sign
		issue(OP_PUSH, 32'h0001_0000);
		issue(OP_PUSH, 32'h0001_0000);
		issue(OP_MUL, $urandom);           // product wraps
		issue(OP_SPARE6, $urandom);
		issue(OP_SPARE7, $urandom);

		repeat (90) random_item(50);
		gap_pct = 66;
		stall_pct = 36;
		repeat (90) random_item(50);

		// no idling; fill to the top under a long result hold-off, overflow, then pop
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		while (level < STACK_DEPTH)
			random_item(94);
		repeat (4) issue(OP_PUSH, pick_word());
		repeat (60) random_item(20);
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/smalu_pkg.sv
design/smalu_ctrl.sv
design/smalu_dpath.sv
design/stack_machine_alu_unit.sv
dv/stack_machine_alu_checker.sv
dv/testbench.sv
